// ===== rtl/dq_pkg.sv =====
// shared constants, types and index helpers for the double-ended queue
package dq_pkg;

  localparam int DEPTH      = 16;
  localparam int WORD_WIDTH = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int SUM_W      = IDX_W + 1;
  localparam int FIELD_W    = 32;
  localparam int ENTRY_W    = 5;
  localparam int CMD_W      = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_QUERY      = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_DROPPED = 2'd1,
    ST_IGNORED = 2'd2
  } status_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic exec;
    logic read;
    logic load;
  } dq_cmd_t;

  // index plus offset, modulo depth; sum stays below twice the depth
  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] idx,
                                                input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(idx) + SUM_W'(off);
    if (sum >= SUM_W'(DEPTH)) sum = sum - SUM_W'(DEPTH);
    return sum[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] idx);
    return (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] wrap_dec(input logic [IDX_W-1:0] idx);
    return (idx == '0) ? IDX_W'(DEPTH - 1) : idx - IDX_W'(1);
  endfunction

  // low field bits of a stored word, zero filled when the word is narrower
  function automatic logic [FIELD_W-1:0] to_field(input logic [WORD_WIDTH-1:0] w);
    logic [WORD_WIDTH+FIELD_W-1:0] ext;
    ext = {{FIELD_W{1'b0}}, w};
    return ext[FIELD_W-1:0];
  endfunction

  function automatic logic [WORD_WIDTH-1:0] to_slot(input logic [FIELD_W-1:0] d);
    logic [WORD_WIDTH+FIELD_W-1:0] ext;
    ext = {{WORD_WIDTH{1'b0}}, d};
    return ext[WORD_WIDTH-1:0];
  endfunction

  function automatic logic [ENTRY_W-1:0] to_entry(input logic [CNT_W-1:0] c);
    logic [CNT_W+ENTRY_W-1:0] ext;
    ext = {{ENTRY_W{1'b0}}, c};
    return ext[ENTRY_W-1:0];
  endfunction

endpackage

// ===== rtl/dq_chan_if.sv =====
// valid/ready channel interfaces for queue commands and results
interface dq_in_if;
  import dq_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          cmd;
  logic signed [FIELD_W-1:0] data_in;

  modport source (output valid, output cmd, output data_in, input ready);
  modport sink   (input valid, input cmd, input data_in, output ready);
endinterface

interface dq_out_if;
  import dq_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] front_word;
  logic signed [FIELD_W-1:0] back_word;
  logic [ENTRY_W-1:0]        entry_count;
  logic                      is_empty;
  logic                      is_full;
  status_t                   status;

  modport source (output valid, output front_word, output back_word,
                  output entry_count, output is_empty, output is_full,
                  output status, input ready);
  modport sink   (input valid, input front_word, input back_word,
                  input entry_count, input is_empty, input is_full,
                  input status, output ready);
endinterface

// ===== rtl/dq_ctrl.sv =====
// sequencing state machine for the queue: accept, execute, read, load result
module dq_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output dq_pkg::dq_cmd_t cmd
);
  import dq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_READ = 4'b0100,
    S_LOAD = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   load_ok;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  // result register is free when empty or being drained this cycle
  assign load_ok   = (state_r == S_LOAD) && (!out_valid_r || out_ready);

  assign cmd.capture = in_valid && in_ready;
  assign cmd.exec    = (state_r == S_EXEC);
  assign cmd.read    = (state_r == S_READ);
  assign cmd.load    = load_ok;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_EXEC;
      S_EXEC: state_nxt = S_READ;
      S_READ: state_nxt = S_LOAD;
      S_LOAD: if (load_ok) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    priority if (load_ok) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/dq_datapath.sv =====
// queue pointers, slot memory and result register
module dq_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  dq_pkg::dq_cmd_t                   cmd,
  input  logic [dq_pkg::CMD_W-1:0]          in_cmd,
  input  logic signed [dq_pkg::FIELD_W-1:0] in_data,
  output logic signed [dq_pkg::FIELD_W-1:0] front_word,
  output logic signed [dq_pkg::FIELD_W-1:0] back_word,
  output logic [dq_pkg::ENTRY_W-1:0]        entry_count,
  output logic                              is_empty,
  output logic                              is_full,
  output dq_pkg::status_t                   status
);
  import dq_pkg::*;

  logic [CMD_W-1:0]      cmd_r;
  logic [WORD_WIDTH-1:0] data_r;
  logic [IDX_W-1:0]      head_r, head_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  status_t               status_r, status_nxt;

  logic [WORD_WIDTH-1:0] slot_mem [DEPTH];
  logic [WORD_WIDTH-1:0] rd_front_r, rd_back_r;

  logic                  q_full, q_empty;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [IDX_W-1:0]      back_idx;
  logic [IDX_W-1:0]      front_dec;

  logic signed [FIELD_W-1:0] front_word_r, back_word_r;
  logic [ENTRY_W-1:0]        entry_count_r;
  logic                      is_empty_r, is_full_r;
  status_t                   status_out_r;

  assign q_full    = (count_r == CNT_W'(DEPTH));
  assign q_empty   = (count_r == '0);
  assign front_dec = wrap_dec(head_r);
  assign back_idx  = wrap_add(head_r, count_r - CNT_W'(1));

  always_comb begin
    head_nxt   = head_r;
    count_nxt  = count_r;
    status_nxt = ST_DONE;
    wr_en      = 1'b0;
    wr_addr    = wrap_add(head_r, count_r);
    unique case (cmd_r)
      CMD_PUSH_BACK: begin
        if (q_full) begin
          status_nxt = ST_DROPPED;
        end else begin
          wr_en     = 1'b1;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      CMD_PUSH_FRONT: begin
        wr_addr = front_dec;
        if (q_full) begin
          status_nxt = ST_DROPPED;
        end else begin
          wr_en     = 1'b1;
          head_nxt  = front_dec;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      CMD_POP_FRONT: begin
        if (q_empty) begin
          status_nxt = ST_IGNORED;
        end else begin
          head_nxt  = wrap_inc(head_r);
          count_nxt = count_r - CNT_W'(1);
        end
      end
      CMD_POP_BACK: begin
        if (q_empty) begin
          status_nxt = ST_IGNORED;
        end else begin
          count_nxt = count_r - CNT_W'(1);
        end
      end
      default: begin
        status_nxt = ST_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else if (cmd.exec) begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r  <= in_cmd;
      data_r <= to_slot(in_data);
    end
    if (cmd.exec) status_r <= status_nxt;
  end

  // slot memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) slot_mem[wr_addr] <= data_r;
    if (cmd.read) begin
      rd_front_r <= slot_mem[head_r];
      rd_back_r  <= slot_mem[back_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      front_word_r  <= q_empty ? '0 : to_field(rd_front_r);
      back_word_r   <= q_empty ? '0 : to_field(rd_back_r);
      entry_count_r <= to_entry(count_r);
      is_empty_r    <= q_empty;
      is_full_r     <= q_full;
      status_out_r  <= status_r;
    end
  end

  assign front_word  = front_word_r;
  assign back_word   = back_word_r;
  assign entry_count = entry_count_r;
  assign is_empty    = is_empty_r;
  assign is_full     = is_full_r;
  assign status      = status_out_r;

endmodule

// ===== rtl/double_ended_queue_unit.sv =====
// top level of the double-ended queue: controller plus datapath
// an accepted transaction steps through execute, read and load before its result shows valid
// one transaction in flight at a time: input is ready again only after the
//   controller's accept, execute, read and load sequence around the registered slot reads
// a result left waiting holds the next transaction in load, and input stalls
// reset (synchronous, rst_n low): queue empty, head at slot 0, no result valid
module double_ended_queue_unit (
  input  logic   clk,
  input  logic   rst_n,
  dq_in_if.sink  in_chan,
  dq_out_if.source out_chan
);
  import dq_pkg::*;

  dq_cmd_t ctrl_cmd;

  // sequencing: ready only between transactions, result held until taken
  dq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cmd       (ctrl_cmd)
  );

  // pointers, slot memory and the result register
  dq_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (ctrl_cmd),
    .in_cmd      (in_chan.cmd),
    .in_data     (in_chan.data_in),
    .front_word  (out_chan.front_word),
    .back_word   (out_chan.back_word),
    .entry_count (out_chan.entry_count),
    .is_empty    (out_chan.is_empty),
    .is_full     (out_chan.is_full),
    .status      (out_chan.status)
  );

endmodule

// ===== rtl/dq_checker.sv =====
// port-level checks for the double-ended queue, bound to the top level
module dq_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [dq_pkg::FIELD_W-1:0] front_word,
  input logic [dq_pkg::ENTRY_W-1:0]        entry_count,
  input logic                              is_empty,
  input logic                              is_full,
  input dq_pkg::status_t                   status
);
  import dq_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(front_word) && $stable(entry_count))
    else $error("result changed while stalled");

  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (is_empty == (entry_count == '0)) &&
                  (is_full == (entry_count == ENTRY_W'(DEPTH))))
    else $error("empty or full flag disagrees with entry count");

  a_dropped_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == ST_DROPPED) |-> is_full)
    else $error("push dropped while queue not full");

  a_ignored_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == ST_IGNORED) |-> is_empty && (front_word == '0))
    else $error("pop ignored while queue not empty");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction accepted while one is in flight");

endmodule

bind double_ended_queue_unit dq_checker u_dq_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_chan.valid),
  .in_ready    (in_chan.ready),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .front_word  (out_chan.front_word),
  .entry_count (out_chan.entry_count),
  .is_empty    (out_chan.is_empty),
  .is_full     (out_chan.is_full),
  .status      (out_chan.status)
);
